@@ rtl/mtlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mtlpc_pkg: shared types and constants
// request codes, config register indexes and sequencer states
// ----------------------------------------------------------------------------
package mtlpc_pkg;

  typedef enum logic [2:0] {
    REQ_RENDER  = 3'd0,
    REQ_VWRITE  = 3'd1,
    REQ_PAL     = 3'd2,
    REQ_SPRITE  = 3'd3,
    REQ_SPCOUNT = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_SCROLL1  = 3'd1,
    CFG_SCROLL2  = 3'd2,
    CFG_WIN2     = 3'd3,
    CFG_SPWIN    = 3'd4,
    CFG_SHADE    = 3'd5
  } cfg_idx_t;

  localparam logic [13:0] TILE_BASE = 14'h2000;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_MAPRD  = 11'b00000000010,
    ST_MAPWT  = 11'b00000000100,
    ST_TILERD = 11'b00000001000,
    ST_TILEWT = 11'b00000010000,
    ST_LDONE  = 11'b00000100000,
    ST_SPCHK  = 11'b00001000000,
    ST_SPRD   = 11'b00010000000,
    ST_SPWT   = 11'b00100000000,
    ST_SPDONE = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_t;

  // shade lookup: 15 - pool entry, replicated into three nibbles
  function automatic logic [11:0] gray_of(logic [31:0] pool, logic [2:0] idx);
    logic [3:0] s;
    s = 4'd15 - pool[{idx, 2'b00} +: 4];
    return {s, s, s};
  endfunction

endpackage

@@ rtl/mtlpc_ram.sv @@
// ----------------------------------------------------------------------------
// mtlpc_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module mtlpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/mono_tile_layer_pixel_compositor_unit.sv @@
// ----------------------------------------------------------------------------
// mono_tile_layer_pixel_compositor_unit: monochrome tile/sprite compositor
// back color, two scrolled tile layers and a line sprite list per pixel
// ----------------------------------------------------------------------------
// sequence: a render reads map entry and tile word per enabled layer, then
//   checks sprites in list order, fetching the tile of each hit until one
//   is drawn, and ends with the result; writes complete in the idle state
// throughput: one beat at a time, busy stays high until the beat is done;
//   the single video memory port paces every tile and map read
// reset: synchronous active-low, clears config and control registers,
//   palettes, sprites; not video memory; the receiver cannot stall out_valid
module mono_tile_layer_pixel_compositor_unit #(
  parameter int MAX_LINE_SPRITES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_hpos,
  input  logic [7:0]  in_vpos,
  input  logic [12:0] in_location,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [1:0]  out_source,
  output logic [11:0] out_gray_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
  localparam int CW = $clog2(MAX_LINE_SPRITES + 1);

  // config registers
  logic [15:0] mode_r, scroll1_r, scroll2_r, spwin_r;
  logic [31:0] win2_r, shade_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; scroll1_r <= '0; scroll2_r <= '0;
      win2_r <= '0; spwin_r <= '0; shade_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mtlpc_pkg::CFG_MODE:    mode_r    <= cfg_data[15:0];
        mtlpc_pkg::CFG_SCROLL1: scroll1_r <= cfg_data[15:0];
        mtlpc_pkg::CFG_SCROLL2: scroll2_r <= cfg_data[15:0];
        mtlpc_pkg::CFG_WIN2:    win2_r    <= cfg_data;
        mtlpc_pkg::CFG_SPWIN:   spwin_r   <= cfg_data[15:0];
        mtlpc_pkg::CFG_SHADE:   shade_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic [2:0]  req_r;
  logic [7:0]  h_r, v_r;
  logic [12:0] loc_r;
  logic [31:0] data_r;

  // palettes and sprite list (small, reset to zero)
  logic [11:0] pal_r [16];
  logic [31:0] spr_r [MAX_LINE_SPRITES];
  logic [CW-1:0] spcnt_r;

  // sequencer
  mtlpc_pkg::state_t st_r, st_nxt;
  logic        layer_r;        // 0 layer one, 1 layer two
  logic [CW-1:0] si_r;         // sprite scan index
  logic [15:0] tile_r;         // map entry of current layer
  logic [1:0]  src_r;
  logic [11:0] gray_r;
  logic        out_valid_r;

  // video memory port
  logic        vm_we;
  logic [12:0] vm_addr;
  logic [15:0] vm_rdata;

  mtlpc_ram #(.WIDTH(16), .DEPTH(8192)) u_vram (
    .clk(clk), .we(vm_we), .addr(vm_addr), .wdata(data_r[15:0]), .rdata(vm_rdata)
  );

  // layer coordinates
  logic [15:0] scroll;
  logic [2:0]  mbase;
  logic [7:0]  sy, sx;
  assign scroll = layer_r ? scroll2_r : scroll1_r;
  assign mbase  = layer_r ? mode_r[15:13] : mode_r[12:10];
  assign sy = v_r + scroll[15:8];
  assign sx = h_r + scroll[7:0];

  logic [13:0] map_byte;
  assign map_byte = {mbase, 11'd0} + {3'd0, sy[7:3], 6'd0} + {8'd0, sx[7:3], 1'b0};

  // current sprite
  logic [SW-1:0] sidx;
  logic [31:0]   spr;
  logic [7:0]    spx, spy;
  logic [8:0]    hx_diff;
  logic          sp_hit, sp_win_skip, in_spwin;
  assign sidx = si_r[SW-1:0];
  assign spr  = spr_r[sidx];
  assign spx  = spr[31:24];
  assign spy  = spr[23:16];
  assign hx_diff = {1'b0, h_r} - {1'b0, spx};
  assign sp_hit  = !hx_diff[8] && (hx_diff[7:3] == 5'd0);
  assign in_spwin = (h_r >= spwin_r[7:0]) && (h_r <= spwin_r[15:8]);
  assign sp_win_skip = mode_r[5] && spr[12] && !in_spwin;

  // shared tile fetch address: layer tile or sprite
  logic        is_spr;
  logic [8:0]  t_idx;
  logic [2:0]  row, col;
  logic [7:0]  spdy;
  assign is_spr = st_r[7] | st_r[8] | st_r[9]; // sprite fetch states
  assign spdy   = v_r - spy;
  assign t_idx  = is_spr ? spr[8:0] : tile_r[8:0];
  assign row = is_spr ? (spdy[2:0] ^ {3{spr[15]}}) : (sy[2:0] ^ {3{tile_r[15]}});
  assign col = is_spr ? (hx_diff[2:0] ^ {3{spr[14]}}) : (sx[2:0] ^ {3{tile_r[14]}});

  logic [13:0] tbase, taddr;
  assign tbase = mtlpc_pkg::TILE_BASE + {1'b0, t_idx, 4'd0};
  assign taddr = mode_r[6] ? (tbase + {10'd0, row, 1'b0} + {13'd0, col[2]})
                           : (tbase + {10'd0, row, 1'b0});

  // pixel color from fetched word (col/byte sel held stable during wait)
  logic [7:0] pbyte;
  logic [1:0] pcolor;
  logic [2:0] ncol;
  always_comb begin
    pbyte  = taddr[0] ? vm_rdata[15:8] : vm_rdata[7:0];
    ncol   = 3'd7 - col;
    if (mode_r[6]) begin
      pcolor = pbyte[{~col[1:0], 1'b0} +: 2];
    end else begin
      pcolor = {vm_rdata[{1'b1, ncol}], vm_rdata[{1'b0, ncol}]};
    end
  end

  logic [3:0]  pal_sel;
  logic [11:0] pal_w;
  logic [11:0] pgray;
  assign pal_sel = is_spr ? {1'b1, spr[11:9]} : tile_r[12:9];
  assign pal_w   = pal_r[pal_sel];
  assign pgray   = mtlpc_pkg::gray_of(shade_r, pal_w[{pcolor, 1'b0} + {2'b0, pcolor} +: 3]);

  // layer two window test
  logic in_w2, l2_ok;
  always_comb begin
    in_w2 = (v_r >= win2_r[15:8]) && (v_r <= win2_r[31:24])
         && (h_r >= win2_r[7:0]) && (h_r <= win2_r[23:16]);
    if (mode_r[4]) in_w2 = !in_w2;
    l2_ok = mode_r[1] && !(mode_r[3] && !in_w2);
  end

  logic [CW-1:0] si_first;
  assign si_first = '0;

  logic wr_pend_r;

  always_comb begin
    vm_we   = 1'b0;
    vm_addr = taddr[13:1];
    st_nxt  = st_r;
    unique case (st_r)
      mtlpc_pkg::ST_IDLE: ;
      mtlpc_pkg::ST_MAPRD: vm_addr = map_byte[13:1];
      default: ;
    endcase
    if (st_r == mtlpc_pkg::ST_IDLE && req_r == mtlpc_pkg::REQ_VWRITE && busy) begin
      vm_we   = 1'b1;
      vm_addr = loc_r;
    end
  end

  assign busy = (st_r != mtlpc_pkg::ST_IDLE) || wr_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mtlpc_pkg::ST_IDLE;
      wr_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      spcnt_r <= '0;
      for (int i = 0; i < 16; i++) pal_r[i] <= '0;
      for (int i = 0; i < MAX_LINE_SPRITES; i++) spr_r[i] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        mtlpc_pkg::ST_IDLE: begin
          if (wr_pend_r) begin
            wr_pend_r <= 1'b0;
            case (req_r)
              mtlpc_pkg::REQ_PAL:
                if (loc_r < 13'd16) pal_r[loc_r[3:0]] <= data_r[11:0];
              mtlpc_pkg::REQ_SPRITE:
                if ({19'd0, loc_r} < MAX_LINE_SPRITES) spr_r[loc_r[SW-1:0]] <= data_r;
              mtlpc_pkg::REQ_SPCOUNT:
                if ({26'd0, data_r[5:0]} > MAX_LINE_SPRITES)
                  spcnt_r <= CW'(MAX_LINE_SPRITES);
                else
                  spcnt_r <= CW'(data_r[5:0]);
              default: ;
            endcase
          end else if (start) begin
            req_r <= in_req_type; h_r <= in_hpos; v_r <= in_vpos;
            loc_r <= in_location; data_r <= in_write_data;
            if (in_req_type == mtlpc_pkg::REQ_RENDER) begin
              src_r  <= 2'd0;
              gray_r <= mtlpc_pkg::gray_of(shade_r, mode_r[9:7]);
              si_r   <= si_first;
              layer_r <= 1'b0;
              if (mode_r[0]) st_r <= mtlpc_pkg::ST_MAPRD;
              else begin
                layer_r <= 1'b1;
                st_r <= mtlpc_pkg::ST_LDONE;
              end
            end else begin
              wr_pend_r <= 1'b1;
            end
          end
        end
        mtlpc_pkg::ST_MAPRD:  st_r <= mtlpc_pkg::ST_MAPWT;
        mtlpc_pkg::ST_MAPWT: begin
          tile_r <= vm_rdata;
          st_r <= mtlpc_pkg::ST_TILERD;
        end
        mtlpc_pkg::ST_TILERD: st_r <= mtlpc_pkg::ST_TILEWT;
        mtlpc_pkg::ST_TILEWT: begin
          if (!(tile_r[11] && pcolor == 2'd0)) begin
            src_r  <= layer_r ? 2'd2 : 2'd1;
            gray_r <= pgray;
          end
          layer_r <= 1'b1;
          st_r <= layer_r ? mtlpc_pkg::ST_SPCHK : mtlpc_pkg::ST_LDONE;
        end
        mtlpc_pkg::ST_LDONE: begin
          // layer one done or disabled, decide layer two
          if (l2_ok) st_r <= mtlpc_pkg::ST_MAPRD;
          else st_r <= mtlpc_pkg::ST_SPCHK;
        end
        mtlpc_pkg::ST_SPCHK: begin
          if (!mode_r[2] || si_r >= spcnt_r) st_r <= mtlpc_pkg::ST_OUT;
          else if (sp_win_skip || !sp_hit) si_r <= si_r + 1'b1;
          else st_r <= mtlpc_pkg::ST_SPRD;
        end
        mtlpc_pkg::ST_SPRD: st_r <= mtlpc_pkg::ST_SPWT;
        mtlpc_pkg::ST_SPWT: st_r <= mtlpc_pkg::ST_SPDONE;
        mtlpc_pkg::ST_SPDONE: begin
          if ((spr[11] && pcolor == 2'd0) || (!spr[13] && src_r == 2'd2)) begin
            si_r <= si_r + 1'b1;
            st_r <= mtlpc_pkg::ST_SPCHK;
          end else begin
            src_r  <= 2'd3;
            gray_r <= pgray;
            st_r <= mtlpc_pkg::ST_OUT;
          end
        end
        mtlpc_pkg::ST_OUT: begin
          out_valid_r <= 1'b1;
          st_r <= mtlpc_pkg::ST_IDLE;
        end
        default: st_r <= mtlpc_pkg::ST_IDLE;
      endcase
    end
  end

  // registered vm data is held: ram reads the same address again each cycle
  // while waiting, so ST_SPDONE still sees the sprite word

  assign out_valid      = out_valid_r;
  assign out_source     = src_r;
  assign out_gray_color = gray_r;

endmodule

@@ test/mono_tile_layer_pixel_compositor_unit_test.sv @@
// ----------------------------------------------------------------------------
// mono_tile_layer_pixel_compositor_unit_test: compositor regression
// fills video memory, then runs directed corner renders and writes followed
// by random traffic under several register settings; every render is
// predicted in the bench and compared field by field against the dut output
// ----------------------------------------------------------------------------
module mono_tile_layer_pixel_compositor_unit_test;

  localparam int VIDEO_WORDS   = 8192;
  localparam int SPRITE_SLOTS  = 32;
  localparam int PALETTES      = 16;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int DRAIN_CYCLES  = 200;
  // request codes past the last defined one do nothing
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  source;
    logic [11:0] gray;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_hpos = '0;
  logic [7:0]  in_vpos = '0;
  logic [12:0] in_location = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic [1:0]  out_source;
  logic [11:0] out_gray_color;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow of the block's registers and stores
  logic [15:0] mode_r, scroll_one_r, scroll_two_r, sprite_win_r;
  logic [31:0] win_two_r, shade_r;
  logic [15:0] vram [VIDEO_WORDS];
  logic [11:0] palettes [PALETTES];
  logic [31:0] sprites [SPRITE_SLOTS];
  int          sprite_total;

  pixel_t      expected_pixels[$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          burst = 0;  // no sender gaps while set

  always #2 clk = ~clk;

  mono_tile_layer_pixel_compositor_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_hpos(in_hpos), .in_vpos(in_vpos),
    .in_location(in_location), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_source(out_source), .out_gray_color(out_gray_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  // pool entry to replicated gray
  function automatic logic [11:0] shade_gray(logic [2:0] idx);
    logic [3:0] s;
    s = 4'd15 - shade_r[{idx, 2'b00} +: 4];
    return {s, s, s};
  endfunction

  function automatic logic [11:0] palette_gray(logic [3:0] pal, logic [1:0] c);
    logic [11:0] entry;
    entry = palettes[pal];
    return shade_gray(entry[3 * c +: 3]);
  endfunction

  // 2-bit pixel of a tile row, planar or packed per mode b6
  function automatic logic [1:0] tile_color(logic [13:0] base, logic [2:0] row,
                                            logic [2:0] col);
    logic [13:0] a;
    logic [15:0] w;
    logic [7:0]  b;
    if (mode_r[6]) begin
      a = base + {row, 1'b0} + col[2];
      w = vram[a[13:1]];
      b = a[0] ? w[15:8] : w[7:0];
      return b[{~col[1:0], 1'b0} +: 2];
    end
    a = base + {row, 1'b0};
    w = vram[a[13:1]];
    return {w[4'd15 - col], w[4'd7 - col]};
  endfunction

  // one scrolled tile layer; returns 1 when opaque
  function automatic bit layer_gray(logic [7:0] h, logic [7:0] v, logic [15:0] scroll,
                                    logic [2:0] map_base, output logic [11:0] gray);
    logic [7:0]  sx, sy;
    logic [13:0] map_addr, tbase;
    logic [15:0] tile;
    logic [2:0]  row, col;
    logic [1:0]  c;
    sy = v + scroll[15:8];
    sx = h + scroll[7:0];
    map_addr = {map_base, 11'b0} + {sy[7:3], 6'b0} + {sx[7:3], 1'b0};
    tile = vram[map_addr[13:1]];
    tbase = mtlpc_pkg::TILE_BASE + {tile[8:0], 4'b0};
    row = sy[2:0] ^ {3{tile[15]}};
    col = sx[2:0] ^ {3{tile[14]}};
    c = tile_color(tbase, row, col);
    gray = '0;
    if (tile[11] && c == 2'd0) return 0;
    gray = palette_gray(tile[12:9], c);
    return 1;
  endfunction

  function automatic pixel_t composite_pixel(logic [7:0] h, logic [7:0] v);
    pixel_t      p;
    logic [11:0] g;
    logic [31:0] s;
    logic [13:0] tbase;
    logic [7:0]  dy;
    logic [2:0]  row, col;
    logic [1:0]  c;
    bit          in_win;
    int          x;
    p.source = 2'd0;
    p.gray = shade_gray(mode_r[9:7]);
    if (mode_r[0] && layer_gray(h, v, scroll_one_r, mode_r[12:10], g)) begin
      p.source = 2'd1;
      p.gray = g;
    end
    if (mode_r[1]) begin
      in_win = v >= win_two_r[15:8] && v <= win_two_r[31:24] &&
               h >= win_two_r[7:0] && h <= win_two_r[23:16];
      if (mode_r[4]) in_win = !in_win;
      if (!(mode_r[3] && !in_win) && layer_gray(h, v, scroll_two_r, mode_r[15:13], g)) begin
        p.source = 2'd2;
        p.gray = g;
      end
    end
    if (mode_r[2]) begin
      in_win = h >= sprite_win_r[7:0] && h <= sprite_win_r[15:8];
      for (int i = 0; i < sprite_total; i++) begin
        s = sprites[i];
        x = int'(s[31:24]);
        // window-bound sprites drop out outside the sprite window
        if (mode_r[5] && s[12] && !in_win) continue;
        if (int'(h) < x || int'(h) > x + 7) continue;
        tbase = mtlpc_pkg::TILE_BASE + {s[8:0], 4'b0};
        dy = v - s[23:16];
        row = dy[2:0] ^ {3{s[15]}};
        col = 3'(int'(h) - x) ^ {3{s[14]}};
        c = tile_color(tbase, row, col);
        if (s[11] && c == 2'd0) continue;
        // low priority sprite hides behind layer two
        if (!s[13] && p.source == 2'd2) continue;
        p.source = 2'd3;
        p.gray = palette_gray({1'b1, s[11:9]}, c);
        break;
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    pixel_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_source !== want.source) begin
          $error("source expected %0d got %0d", want.source, out_source);
          errors++;
        end
        if (out_gray_color !== want.gray) begin
          $error("gray_color expected %h got %h", want.gray, out_gray_color);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // one request beat; start stays high when the next beat follows at once
  task automatic send_request(logic [2:0] req, logic [7:0] h, logic [7:0] v,
                              logic [12:0] loc, logic [31:0] data);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_req_type = req;
    in_hpos = h;
    in_vpos = v;
    in_location = loc;
    in_write_data = data;
    do @(posedge clk); while (busy);
    // beat accepted at this edge: update the shadow or predict the pixel
    case (req)
      mtlpc_pkg::REQ_RENDER:  expected_pixels.push_back(composite_pixel(h, v));
      mtlpc_pkg::REQ_VWRITE:  vram[loc] = data[15:0];
      mtlpc_pkg::REQ_PAL:     if (loc < PALETTES) palettes[loc[3:0]] = data[11:0];
      mtlpc_pkg::REQ_SPRITE:  if (loc < SPRITE_SLOTS) sprites[loc[4:0]] = data;
      mtlpc_pkg::REQ_SPCOUNT:
        sprite_total = (data[5:0] > SPRITE_SLOTS) ? SPRITE_SLOTS : int'(data[5:0]);
      default: ;
    endcase
  endtask

  // drop start and let every outstanding beat finish
  task automatic drain;
    @(negedge clk) start = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(mtlpc_pkg::cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mtlpc_pkg::CFG_MODE:    mode_r = value[15:0];
      mtlpc_pkg::CFG_SCROLL1: scroll_one_r = value[15:0];
      mtlpc_pkg::CFG_SCROLL2: scroll_two_r = value[15:0];
      mtlpc_pkg::CFG_WIN2:    win_two_r = value;
      mtlpc_pkg::CFG_SPWIN:   sprite_win_r = value[15:0];
      mtlpc_pkg::CFG_SHADE:   shade_r = value;
      default: ;
    endcase
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [15:0] m, logic [15:0] s1, logic [15:0] s2,
                           logic [31:0] w2, logic [15:0] sw, logic [31:0] sp);
    drain();
    write_reg(mtlpc_pkg::CFG_MODE, {16'd0, m});
    write_reg(mtlpc_pkg::CFG_SCROLL1, {16'd0, s1});
    write_reg(mtlpc_pkg::CFG_SCROLL2, {16'd0, s2});
    write_reg(mtlpc_pkg::CFG_WIN2, w2);
    write_reg(mtlpc_pkg::CFG_SPWIN, {16'd0, sw});
    write_reg(mtlpc_pkg::CFG_SHADE, sp);
  endtask

  // ---------------------------------------------------------------- tests

  // every word is written first so no render ever reads unwritten memory
  task automatic test_fill_video_memory;
    burst = 1;
    for (int i = 0; i < VIDEO_WORDS; i++)
      send_request(mtlpc_pkg::REQ_VWRITE, '0, '0, 13'(i), $urandom);
    burst = 0;
  endtask

  task automatic test_directed_corners;
    configure(16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_0000, 16'hFF00, 32'h7654_3210);
    send_request(mtlpc_pkg::REQ_PAL, '0, '0, 13'd0, 32'hFFFF_FFFF);
    send_request(mtlpc_pkg::REQ_PAL, '0, '0, 13'd15, 32'h0000_0AC5);
    send_request(mtlpc_pkg::REQ_PAL, '0, '0, 13'd16, 32'h0000_0FFF);   // out of range, ignored
    send_request(mtlpc_pkg::REQ_PAL, '0, '0, 13'h1FFF, 32'h0000_0123); // ignored
    // sprite at the right edge, no priority, transparent palette
    send_request(mtlpc_pkg::REQ_SPRITE, '0, '0, 13'd0, 32'hFF00_0FFF);
    // high priority flipped sprite at the left edge
    send_request(mtlpc_pkg::REQ_SPRITE, '0, '0, 13'd1, 32'h0007_E000);
    send_request(mtlpc_pkg::REQ_SPRITE, '0, '0, 13'd32, 32'h0000_0000); // slot out of range
    send_request(mtlpc_pkg::REQ_SPCOUNT, '0, '0, '0, 32'hFFFF_FFFF);    // count saturates
    send_request(mtlpc_pkg::REQ_RENDER, 8'd0, 8'd0, '0, '0);
    send_request(mtlpc_pkg::REQ_RENDER, 8'd255, 8'd255, '0, '0);
    send_request(mtlpc_pkg::REQ_RENDER, 8'd255, 8'd0, '0, '0);
    send_request(mtlpc_pkg::REQ_RENDER, 8'd3, 8'd255, '0, '0);
    send_request(REQ_UNKNOWN_LO, 8'hFF, 8'hFF, 13'h1FFF, 32'hFFFF_FFFF);
    send_request(REQ_UNKNOWN_HI, '0, '0, '0, '0);
    send_request(mtlpc_pkg::REQ_SPCOUNT, '0, '0, '0, 32'd2);
    send_request(mtlpc_pkg::REQ_VWRITE, '0, '0, 13'h1FFF, 32'h0000_FFFF);
    send_request(mtlpc_pkg::REQ_RENDER, 8'd7, 8'd128, '0, '0);
    // everything off: back color only
    configure(16'h0000, 16'h0000, 16'hFFFF, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    send_request(mtlpc_pkg::REQ_RENDER, 8'd0, 8'd255, '0, '0);
    send_request(mtlpc_pkg::REQ_RENDER, 8'd128, 8'd64, '0, '0);
  endtask

  task automatic test_random_traffic(int count);
    int          pick, slot;
    logic [7:0]  h;
    logic [12:0] loc;
    logic [31:0] data;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      data = $urandom;
      if (pick < 55) begin
        h = 8'($urandom);
        // aim half the renders at a listed sprite so sprites get hit
        if (sprite_total > 0 && $urandom_range(0, 1)) begin
          slot = $urandom_range(0, sprite_total - 1);
          h = sprites[slot][31:24] + 8'($urandom_range(0, 7));
        end
        send_request(mtlpc_pkg::REQ_RENDER, h, 8'($urandom), 13'($urandom), data);
      end else if (pick < 68) begin
        send_request(mtlpc_pkg::REQ_VWRITE, 8'($urandom), 8'($urandom), 13'($urandom),
                     data);
      end else if (pick < 78) begin
        loc = $urandom_range(0, 4) ? 13'($urandom_range(0, PALETTES - 1)) : 13'($urandom);
        send_request(mtlpc_pkg::REQ_PAL, '0, '0, loc, data);
      end else if (pick < 90) begin
        loc = $urandom_range(0, 4) ? 13'($urandom_range(0, SPRITE_SLOTS - 1)) : 13'($urandom);
        send_request(mtlpc_pkg::REQ_SPRITE, '0, '0, loc, data);
      end else if (pick < 96) begin
        if ($urandom_range(0, 3)) data[5:0] = 6'($urandom_range(0, 12));
        send_request(mtlpc_pkg::REQ_SPCOUNT, '0, '0, '0, data);
      end else begin
        send_request(3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI)),
                     8'($urandom), 8'($urandom), 13'($urandom), data);
      end
    end
    burst = 0;
  endtask

  task automatic test_random_settings;
    for (int phase = 0; phase < 6; phase++) begin
      configure(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                $urandom);
      test_random_traffic(180);
    end
    // all layers and windows on with full-range settings
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    test_random_traffic(110);
  endtask

  initial begin
    mode_r = '0; scroll_one_r = '0; scroll_two_r = '0;
    win_two_r = '0; sprite_win_r = '0; shade_r = '0;
    foreach (palettes[i]) palettes[i] = '0;
    foreach (sprites[i]) sprites[i] = '0;
    foreach (vram[i]) vram[i] = '0;
    sprite_total = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_fill_video_memory();
    test_directed_corners();
    test_random_settings();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mtlpc_pkg.sv
rtl/mtlpc_ram.sv
rtl/mono_tile_layer_pixel_compositor_unit.sv
test/mono_tile_layer_pixel_compositor_unit_test.sv
